[sv/sqlts_pkg.sv]
package sqlts_pkg;

	localparam int MAX_RES    = 4;
	localparam int CNT_W      = $clog2(MAX_RES + 1);
	localparam int IDX_W      = $clog2(MAX_RES);
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int WBUF_LEN   = 8;
	localparam int KW_NUM     = 22;

	typedef enum logic [7:0] {
		M_IDLE = 8'b0000_0001,
		M_LT   = 8'b0000_0010,
		M_GT   = 8'b0000_0100,
		M_BANG = 8'b0000_1000,
		M_STR  = 8'b0001_0000,
		M_ESC  = 8'b0010_0000,
		M_NUM  = 8'b0100_0000,
		M_ID   = 8'b1000_0000
	} mode_t;

	localparam logic [5:0] TK_EOF      = 6'd0;
	localparam logic [5:0] TK_SELECT   = 6'd1;
	localparam logic [5:0] TK_FROM     = 6'd2;
	localparam logic [5:0] TK_WHERE    = 6'd3;
	localparam logic [5:0] TK_INSERT   = 6'd4;
	localparam logic [5:0] TK_INTO     = 6'd5;
	localparam logic [5:0] TK_VALUES   = 6'd6;
	localparam logic [5:0] TK_CREATE   = 6'd7;
	localparam logic [5:0] TK_TABLE    = 6'd8;
	localparam logic [5:0] TK_DELETE   = 6'd9;
	localparam logic [5:0] TK_INT      = 6'd10;
	localparam logic [5:0] TK_VARCHAR  = 6'd11;
	localparam logic [5:0] TK_DECIMAL  = 6'd12;
	localparam logic [5:0] TK_DATETIME = 6'd13;
	localparam logic [5:0] TK_PRIMARY  = 6'd14;
	localparam logic [5:0] TK_KEY      = 6'd15;
	localparam logic [5:0] TK_NOT      = 6'd16;
	localparam logic [5:0] TK_NULL     = 6'd17;
	localparam logic [5:0] TK_IDENT    = 6'd20;
	localparam logic [5:0] TK_NUMBER   = 6'd21;
	localparam logic [5:0] TK_STRING   = 6'd22;
	localparam logic [5:0] TK_COMMA    = 6'd23;
	localparam logic [5:0] TK_LPAREN   = 6'd24;
	localparam logic [5:0] TK_RPAREN   = 6'd25;
	localparam logic [5:0] TK_STAR     = 6'd26;
	localparam logic [5:0] TK_EQ       = 6'd27;
	localparam logic [5:0] TK_LT       = 6'd28;
	localparam logic [5:0] TK_GT       = 6'd29;
	localparam logic [5:0] TK_LE       = 6'd30;
	localparam logic [5:0] TK_GE       = 6'd31;
	localparam logic [5:0] TK_NE       = 6'd32;
	localparam logic [5:0] TK_WITH     = 6'd33;
	localparam logic [5:0] TK_TTL      = 6'd34;
	localparam logic [5:0] TK_DOT      = 6'd35;
	localparam logic [5:0] TK_SEMI     = 6'd36;
	localparam logic [5:0] TK_INNER    = 6'd37;
	localparam logic [5:0] TK_JOIN     = 6'd38;
	localparam logic [5:0] TK_ON       = 6'd39;

	localparam logic [63:0] KW_TEXT [KW_NUM] = '{
		"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE", "TABLE",
		"DELETE", "INT", "VARCHAR", "DECIMAL", "DATETIME", "PRIMARY", "KEY", "NOT",
		"NULL", "WITH", "TTL", "INNER", "JOIN", "ON"
	};

	localparam logic [3:0] KW_LEN [KW_NUM] = '{
		4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5,
		4'd6, 4'd3, 4'd7, 4'd7, 4'd8, 4'd7, 4'd3, 4'd3,
		4'd4, 4'd4, 4'd3, 4'd5, 4'd4, 4'd2
	};

	localparam logic [5:0] KW_CODE [KW_NUM] = '{
		TK_SELECT, TK_FROM, TK_WHERE, TK_INSERT, TK_INTO, TK_VALUES, TK_CREATE, TK_TABLE,
		TK_DELETE, TK_INT, TK_VARCHAR, TK_DECIMAL, TK_DATETIME, TK_PRIMARY, TK_KEY, TK_NOT,
		TK_NULL, TK_WITH, TK_TTL, TK_INNER, TK_JOIN, TK_ON
	};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
	} beat_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] value_byte;
		logic [5:0] token_kind;
		logic       statement_done;
		logic       run_last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic logic [5:0] op_code(input logic [7:0] c);
		logic [5:0] tk;
		unique case (c)
			"(":     tk = TK_LPAREN;
			")":     tk = TK_RPAREN;
			",":     tk = TK_COMMA;
			"*":     tk = TK_STAR;
			";":     tk = TK_SEMI;
			".":     tk = TK_DOT;
			"=":     tk = TK_EQ;
			default: tk = TK_EOF;
		endcase
		return tk;
	endfunction

	function automatic logic [5:0] kw_kind(input logic [WBUF_LEN-1:0][7:0] wb,
			input logic [3:0] len);
		logic [5:0] kind;
		logic       hit;
		logic [2:0] idx;
		kind = TK_IDENT;
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			hit = (KW_LEN[k] == len);
			for (int i = 0; i < WBUF_LEN; i++) begin
				idx = 3'(int'(KW_LEN[k]) - 1 - i);
				if (i < int'(KW_LEN[k]) && wb[i] != KW_TEXT[k][idx*8 +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				kind = KW_CODE[k];
			end
		end
		return kind;
	endfunction

	function automatic res_t mk_byte(input logic [7:0] c);
		res_t r;
		r = '0;
		r.value_byte = c;
		return r;
	endfunction

	function automatic res_t mk_end(input logic [5:0] tk);
		res_t r;
		r = '0;
		r.item_kind  = 1'b1;
		r.token_kind = tk;
		return r;
	endfunction

endpackage

[sv/sqlts_scan.sv]
module sqlts_scan import sqlts_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  beat_t                     beat,
	output res_t [MAX_RES-1:0]        res,
	output logic [CNT_W-1:0]          res_cnt
);

	mode_t                       mode_q, mode_b;
	logic                        qdbl_q, qdbl_n;
	logic [3:0]                  wlen_q, wlen_b, wlen_n;
	logic [WBUF_LEN-1:0][7:0]    wbuf_q, wbuf_b;
	logic [5:0]                  kw_n;
	logic [7:0]                  c;
	logic                        again;
	logic [5:0]                  op;
	logic [CNT_W-1:0]            n;

	assign c  = beat.text_byte;
	assign op = op_code(c);

	always_comb begin
		wbuf_b = wbuf_q;
		wlen_b = wlen_q;
		if (beat.byte_present) begin
			if (mode_q == M_ID && (is_alpha(c) || is_digit(c) || c == "_")) begin
				if (wlen_q < 4'd8) begin
					wbuf_b[wlen_q[2:0]] = upcase(c);
				end
				if (wlen_q < 4'd15) begin
					wlen_b = wlen_q + 4'd1;
				end
			end else if (mode_q != M_STR && mode_q != M_ESC && (is_alpha(c) || c == "_")) begin
				wbuf_b[0] = upcase(c);
				wlen_b    = 4'd1;
			end
		end
		wlen_n = beat.end_of_text ? 4'd0 : wlen_b;
	end

	assign kw_n = kw_kind(wbuf_b, wlen_b);

	always_comb begin
		res    = '0;
		n      = '0;
		mode_b = mode_q;
		qdbl_n = qdbl_q;
		again  = 1'b0;
		if (beat.byte_present) begin
			unique case (mode_q)
				M_LT: begin
					mode_b = M_IDLE;
					if (c == "=") begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
						res[n[IDX_W-1:0]] = mk_end(TK_LE); n = n + CNT_W'(1);
					end else if (c == ">") begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
						res[n[IDX_W-1:0]] = mk_end(TK_NE); n = n + CNT_W'(1);
					end else begin
						res[n[IDX_W-1:0]] = mk_end(TK_LT); n = n + CNT_W'(1);
						again = 1'b1;
					end
				end
				M_GT: begin
					mode_b = M_IDLE;
					if (c == "=") begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
						res[n[IDX_W-1:0]] = mk_end(TK_GE); n = n + CNT_W'(1);
					end else begin
						res[n[IDX_W-1:0]] = mk_end(TK_GT); n = n + CNT_W'(1);
						again = 1'b1;
					end
				end
				M_BANG: begin
					mode_b = M_IDLE;
					if (c == "=") begin
						res[n[IDX_W-1:0]] = mk_byte("!"); n = n + CNT_W'(1);
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
						res[n[IDX_W-1:0]] = mk_end(TK_NE); n = n + CNT_W'(1);
					end else begin
						again = 1'b1;
					end
				end
				M_STR: begin
					if (c == (qdbl_q ? "\"" : "'")) begin
						res[n[IDX_W-1:0]] = mk_end(TK_STRING); n = n + CNT_W'(1);
						mode_b = M_IDLE;
					end else if (c == "\\" && !beat.end_of_text) begin
						mode_b = M_ESC;
					end else begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
					end
				end
				M_ESC: begin
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
					mode_b = M_STR;
				end
				M_NUM: begin
					if (is_digit(c) || c == ".") begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
					end else begin
						res[n[IDX_W-1:0]] = mk_end(TK_NUMBER); n = n + CNT_W'(1);
						mode_b = M_IDLE;
						again  = 1'b1;
					end
				end
				M_ID: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
					end else begin
						res[n[IDX_W-1:0]] = mk_end(kw_n); n = n + CNT_W'(1);
						mode_b = M_IDLE;
						again  = 1'b1;
					end
				end
				default: begin
					mode_b = M_IDLE;
					again  = 1'b1;
				end
			endcase
			if (again) begin
				if (op != TK_EOF) begin
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
					res[n[IDX_W-1:0]] = mk_end(op); n = n + CNT_W'(1);
				end else if (c == "<") begin
					mode_b = M_LT;
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
				end else if (c == ">") begin
					mode_b = M_GT;
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
				end else if (c == "!") begin
					mode_b = M_BANG;
				end else if (c == "'" || c == "\"") begin
					mode_b = M_STR;
					qdbl_n = (c == "\"");
				end else if (is_digit(c)) begin
					mode_b = M_NUM;
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
				end else if (is_alpha(c) || c == "_") begin
					mode_b = M_ID;
					res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
				end
			end
		end
		if (beat.end_of_text) begin
			unique case (mode_b)
				M_LT: begin
					res[n[IDX_W-1:0]] = mk_end(TK_LT); n = n + CNT_W'(1);
				end
				M_GT: begin
					res[n[IDX_W-1:0]] = mk_end(TK_GT); n = n + CNT_W'(1);
				end
				M_STR: begin
					res[n[IDX_W-1:0]] = mk_end(TK_STRING); n = n + CNT_W'(1);
				end
				M_ESC: begin
					res[n[IDX_W-1:0]] = mk_byte("\\"); n = n + CNT_W'(1);
					res[n[IDX_W-1:0]] = mk_end(TK_STRING); n = n + CNT_W'(1);
				end
				M_NUM: begin
					res[n[IDX_W-1:0]] = mk_end(TK_NUMBER); n = n + CNT_W'(1);
				end
				M_ID: begin
					res[n[IDX_W-1:0]] = mk_end(kw_n); n = n + CNT_W'(1);
				end
				default: begin
				end
			endcase
			res[n[IDX_W-1:0]] = mk_end(TK_EOF);
			res[n[IDX_W-1:0]].statement_done = 1'b1;
			n = n + CNT_W'(1);
			mode_b = M_IDLE;
		end
		if (n != '0) begin
			res[IDX_W'(n - CNT_W'(1))].run_last = 1'b1;
		end
	end

	assign res_cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			qdbl_q <= 1'b0;
			wlen_q <= '0;
		end else if (go) begin
			mode_q <= mode_b;
			qdbl_q <= qdbl_n;
			wlen_q <= wlen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			wbuf_q <= wbuf_b;
		end
	end

endmodule

[sv/sqlts_fifo.sv]
module sqlts_fifo import sqlts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CNT_W-1:0]      push_cnt,
	input  res_t [MAX_RES-1:0]    push_data,
	input  logic                  pop,
	output res_t                  head,
	output logic                  not_empty,
	output logic                  room
);

	res_t               mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0]  count_q;

	assign head      = mem[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign room      = count_q <= FCNT_W'(FIFO_DEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (CNT_W'(k) < push_cnt) begin
				mem[wr_ptr_q + PTR_W'(k)] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + FCNT_W'(push_cnt) - FCNT_W'(pop);
		end
	end

endmodule

[sv/sql_token_scanner.sv]
// SQL token scanner: takes statement text one byte per input beat and emits
// token value bytes and token-end beats on the output channel.
// Input channel: in_valid / in_stall with text_byte, byte_present and
// end_of_text. Output channel: out_valid / out_stall with item_kind,
// value_byte, token_kind, statement_done and run_last (set on the last
// output beat caused by one input beat).
// An accepted beat is held in the input register; its output beats are
// made combinationally and written into the result queue, whose head
// drives the output. Throughput: one input beat per cycle unless stalled;
// each makes zero to four output beats, which drain one per cycle while
// out_stall is low through an 8-entry result queue. in_stall rises only
// with a beat in the input register and under four free queue entries.
// When the receiver raises out_stall the head beat holds and the queue
// fills; the input side then stalls.
// Reset empties the queue and the input register and returns the scanner
// to the between-tokens state.
module sql_token_scanner import sqlts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        byte_present,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [7:0]  value_byte,
	output logic [5:0]  token_kind,
	output logic        statement_done,
	output logic        run_last
);

	beat_t               beat_s1;
	logic                valid_s1;
	logic                room;
	logic                consume;
	res_t [MAX_RES-1:0]  res;
	logic [CNT_W-1:0]    res_cnt;
	logic [CNT_W-1:0]    push_cnt;
	res_t                head;
	logic                not_empty;
	logic                pop;

	assign consume  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign push_cnt = consume ? res_cnt : '0;
	assign pop      = not_empty && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= '{text_byte: text_byte, byte_present: byte_present,
				end_of_text: end_of_text};
		end
	end

	sqlts_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (consume),
		.beat    (beat_s1),
		.res     (res),
		.res_cnt (res_cnt)
	);

	sqlts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (res),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign out_valid      = not_empty;
	assign item_kind      = head.item_kind;
	assign value_byte     = head.value_byte;
	assign token_kind     = head.token_kind;
	assign statement_done = head.statement_done;
	assign run_last       = head.run_last;

endmodule
